>>> sv/rlfp_pkg.sv
package rlfp_pkg;

	// Parse phases, one-hot
	typedef enum logic [7:0] {
		PH_PREFIX = 8'b0000_0001,
		PH_COMMA  = 8'b0000_0010,
		PH_ID     = 8'b0000_0100,
		PH_COL1   = 8'b0000_1000,
		PH_COL2   = 8'b0001_0000,
		PH_MSGID  = 8'b0010_0000,
		PH_PAY    = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	// Verdict codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOT_US = 2'd1,
		ST_ERR    = 2'd2
	} status_t;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] OFFSET_MAX = 8'hFF;
	localparam logic [2:0] PREFIX_LEN = 3'd5;
	localparam logic [1:0] COMMAS_TO_ID = 2'd2;

	// Per-line parser state
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  field_count;
		logic [7:0]  line_offset;
		logic [1:0]  comma_seen;
		logic [7:0]  held_char;
		logic        held_valid;
		logic [63:0] id_capture;
		logic [3:0]  id_capture_len;
		logic [7:0]  pay_start;
	} line_state_t;

	localparam line_state_t LINE_RESET = '{
		phase:          PH_PREFIX,
		field_count:    8'd0,
		line_offset:    8'd0,
		comma_seen:     2'd0,
		held_char:      8'd0,
		held_valid:     1'b0,
		id_capture:     64'd0,
		id_capture_len: 4'd0,
		pay_start:      8'd0
	};

	// One verdict as it leaves the parser
	typedef struct packed {
		status_t     status;
		logic [63:0] msg_id;
		logic [3:0]  msg_id_len;
		logic [7:0]  payload_start;
		logic [7:0]  pay_len;
	} verdict_t;

	// Verdict push from the parser into the output register
	typedef struct packed {
		logic     valid;
		verdict_t data;
	} verdict_push_t;

	// Expected line prefix "+RCV=" by position
	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h2B;
			3'd1: ch = 8'h52;
			3'd2: ch = 8'h43;
			3'd3: ch = 8'h56;
			3'd4: ch = 8'h3D;
			default: ch = CHAR_NUL;
		endcase
		return ch;
	endfunction

endpackage

>>> sv/rlfp_char_if.sv
interface rlfp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_line;

	modport source (output valid, output char_in, output end_of_line, input ready);
	modport sink (input valid, input char_in, input end_of_line, output ready);
endinterface

>>> sv/rlfp_verdict_if.sv
interface rlfp_verdict_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] msg_id;
	logic [3:0]  msg_id_len;
	logic [7:0]  payload_start;
	logic [7:0]  pay_len;

	modport source (output valid, output status, output msg_id, output msg_id_len,
		output payload_start, output pay_len, input ready);
	modport sink (input valid, input status, input msg_id, input msg_id_len,
		input payload_start, input pay_len, output ready);
endinterface

>>> sv/rlfp_parse_core.sv
module rlfp_parse_core #(
	parameter int ID_CHARS    = 8,
	parameter int MSGID_MAX   = 8,
	parameter int PAYLOAD_MAX = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   node_id_we,
	input  logic [63:0]            node_id,
	rlfp_char_if.sink              in_ch,
	input  logic                   out_can_take,
	output rlfp_pkg::verdict_push_t push
);
	import rlfp_pkg::*;

	localparam logic [7:0] ID_CHARS_W    = 8'(ID_CHARS);
	localparam logic [3:0] MSGID_MAX_W   = 4'(MSGID_MAX);
	localparam logic [7:0] PAYLOAD_MAX_W = 8'(PAYLOAD_MAX);

	logic        in_valid_s1;
	logic [7:0]  char_s1;
	logic        eol_s1;
	logic [63:0] node_id_q;
	line_state_t line_q;
	line_state_t line_nxt;
	logic        emit;
	status_t     status;
	logic        do_payload;
	logic        s1_fire;
	logic [7:0]  fc_inc;
	logic [1:0]  cs_inc;
	logic [3:0]  len_inc;
	logic [7:0]  pay_inc;

	// Node identifier register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= 64'd0;
		end else if (node_id_we) begin
			node_id_q <= node_id;
		end
	end

	// Advance the input register unless a verdict finds the output register full
	assign s1_fire     = in_valid_s1 && (!emit || out_can_take);
	assign in_ch.ready = !in_valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			in_valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			char_s1 <= in_ch.char_in;
			eol_s1  <= in_ch.end_of_line;
		end
	end

	// Step the line state by one character
	always_comb begin
		line_nxt   = line_q;
		emit       = 1'b0;
		status     = ST_ERR;
		do_payload = 1'b0;
		fc_inc     = line_q.field_count + 8'd1;
		cs_inc     = line_q.comma_seen + 2'd1;
		len_inc    = line_q.id_capture_len + 4'd1;
		pay_inc    = 8'd0;

		if (eol_s1) begin
			emit     = (line_q.phase != PH_DONE);
			line_nxt = LINE_RESET;
		end else begin
			if (line_q.line_offset != OFFSET_MAX) begin
				line_nxt.line_offset = line_q.line_offset + 8'd1;
			end
			if (line_q.phase == PH_DONE) begin
				emit = 1'b0;
			end else if (char_s1 == CHAR_NUL) begin
				emit = 1'b1;
			end else begin
				unique case (line_q.phase)
					PH_PREFIX: begin
						if (char_s1 != prefix_char(line_q.field_count[2:0])) begin
							emit = 1'b1;
						end else if (fc_inc[2:0] == PREFIX_LEN) begin
							line_nxt.phase       = PH_COMMA;
							line_nxt.field_count = 8'd0;
						end else begin
							line_nxt.field_count = fc_inc;
						end
					end
					PH_COMMA: begin
						if (char_s1 == CHAR_COMMA) begin
							line_nxt.comma_seen = cs_inc;
							if (cs_inc >= COMMAS_TO_ID) begin
								line_nxt.phase       = PH_ID;
								line_nxt.field_count = 8'd0;
							end
						end
					end
					PH_ID: begin
						if (char_s1 != node_id_q[{line_q.field_count[2:0], 3'b000} +: 8]) begin
							emit   = 1'b1;
							status = ST_NOT_US;
						end else begin
							line_nxt.field_count = fc_inc;
							if (fc_inc >= ID_CHARS_W) begin
								line_nxt.phase = PH_COL1;
							end
						end
					end
					PH_COL1: begin
						if (char_s1 != CHAR_COLON) begin
							emit = 1'b1;
						end else begin
							line_nxt.phase = PH_COL2;
						end
					end
					PH_COL2: begin
						if (char_s1 != CHAR_COLON) begin
							emit = 1'b1;
						end else begin
							line_nxt.phase      = PH_MSGID;
							line_nxt.held_valid = 1'b0;
						end
					end
					PH_MSGID: begin
						if (!line_q.held_valid) begin
							line_nxt.held_char  = char_s1;
							line_nxt.held_valid = 1'b1;
						end else if (line_q.held_char == CHAR_COLON && char_s1 == CHAR_COLON) begin
							// "::" closes the message id
							line_nxt.held_valid = 1'b0;
							if (line_q.id_capture_len == 4'd0) begin
								emit = 1'b1;
							end else begin
								pay_inc = (line_q.line_offset != OFFSET_MAX) ?
									line_q.line_offset + 8'd1 : OFFSET_MAX;
								line_nxt.phase       = PH_PAY;
								line_nxt.field_count = 8'd0;
								line_nxt.pay_start   = pay_inc;
							end
						end else begin
							// Commit the held character; at the limit fall into payload
							line_nxt.id_capture[{line_q.id_capture_len[2:0], 3'b000} +: 8] =
								line_q.held_char;
							line_nxt.id_capture_len = len_inc;
							if (len_inc >= MSGID_MAX_W) begin
								line_nxt.held_valid  = 1'b0;
								line_nxt.phase       = PH_PAY;
								line_nxt.field_count = 8'd0;
								line_nxt.pay_start   = line_q.line_offset;
								do_payload           = 1'b1;
							end else begin
								line_nxt.held_char = char_s1;
							end
						end
					end
					PH_PAY: begin
						do_payload = 1'b1;
					end
					default: begin
						emit = 1'b0;
					end
				endcase

				// Count a payload character or close on the comma
				if (do_payload) begin
					if (char_s1 == CHAR_COMMA) begin
						emit   = 1'b1;
						status = ST_OK;
					end else begin
						line_nxt.field_count = line_nxt.field_count + 8'd1;
						if (line_nxt.field_count >= PAYLOAD_MAX_W) begin
							emit = 1'b1;
						end
					end
				end
			end
			if (emit) begin
				line_nxt.phase = PH_DONE;
			end
		end
	end

	// Build the verdict; failures carry zero fields
	always_comb begin
		push.valid       = in_valid_s1 && emit && out_can_take;
		push.data.status = status;
		if (status == ST_OK) begin
			push.data.msg_id        = line_nxt.id_capture;
			push.data.msg_id_len    = line_nxt.id_capture_len;
			push.data.payload_start = line_nxt.pay_start;
			push.data.pay_len       = line_nxt.field_count;
		end else begin
			push.data.msg_id        = 64'd0;
			push.data.msg_id_len    = 4'd0;
			push.data.payload_start = 8'd0;
			push.data.pay_len       = 8'd0;
		end
	end

	// Line state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_RESET;
		end else if (s1_fire) begin
			line_q <= line_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_verdict_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> line_q.phase != PH_DONE)
		else $error("verdict pushed for a line that already has one");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.data.status != ST_OK |->
			push.data.msg_id == 64'd0 && push.data.msg_id_len == 4'd0 &&
			push.data.payload_start == 8'd0 && push.data.pay_len == 8'd0)
		else $error("failed verdict carries nonzero fields");

	a_offset_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !eol_s1 |=> line_q.line_offset >= $past(line_q.line_offset))
		else $error("line offset moved backward within a line");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !s1_fire |=> in_valid_s1 && $stable(char_s1) && $stable(eol_s1))
		else $error("stalled input register lost its character");
`endif

endmodule

>>> sv/rlfp_out_stage.sv
module rlfp_out_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rlfp_pkg::verdict_push_t push,
	output logic                    out_can_take,
	rlfp_verdict_if.source          out_ch
);
	import rlfp_pkg::*;

	logic     out_valid_q;
	verdict_t data_q;

	// Room when empty or when the held verdict leaves this cycle
	assign out_can_take = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_can_take) begin
			out_valid_q <= push.valid;
		end
	end

	// Load the verdict payload
	always_ff @(posedge clk) begin
		if (push.valid) begin
			data_q <= push.data;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = data_q.status;
	assign out_ch.msg_id        = data_q.msg_id;
	assign out_ch.msg_id_len    = data_q.msg_id_len;
	assign out_ch.payload_start = data_q.payload_start;
	assign out_ch.pay_len       = data_q.pay_len;

endmodule

>>> sv/receive_line_field_parser.sv
// Receive line field parser. Characters of a "+RCV=" line enter on in_ch, one
// transaction per character, the line closed by an end_of_line transaction (a
// char_in of zero also ends parsing). Exactly one verdict per line leaves on
// out_ch: data received with message id and payload position, not addressed
// to this node, or parse error. The block takes one character every cycle; a
// character is held in the input register, where the line state machine
// steps, and its verdict then sits in the output register. in_ch only
// stalls when a verdict is due while the output register still holds one
// that out_ch has not taken. Write node_id (first character in the low byte)
// only while no line is in progress.
module receive_line_field_parser #(
	parameter int ID_CHARS    = 8,
	parameter int MSGID_MAX   = 8,
	parameter int PAYLOAD_MAX = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           node_id_we,
	input  logic [63:0]    node_id,
	rlfp_char_if.sink      in_ch,
	rlfp_verdict_if.source out_ch
);
	import rlfp_pkg::*;

	verdict_push_t push;
	logic          out_can_take;

	// Line state machine
	rlfp_parse_core #(
		.ID_CHARS    (ID_CHARS),
		.MSGID_MAX   (MSGID_MAX),
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.node_id_we   (node_id_we),
		.node_id      (node_id),
		.in_ch        (in_ch),
		.out_can_take (out_can_take),
		.push         (push)
	);

	// Verdict output register
	rlfp_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.out_can_take (out_can_take),
		.out_ch       (out_ch)
	);

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rlfp_pkg::*;

	localparam int ID_CHARS        = 8;
	localparam int MSGID_MAX       = 8;
	localparam int PAYLOAD_MAX     = 64;
	localparam int RANDOM_ITEMS    = 480;
	localparam int VERDICT_LATENCY = 2;
	localparam int PRESSURE_CYCLES = 300;
	localparam int STUCK_LIMIT     = 3000;

	localparam logic [39:0] RCV_TAG = "+RCV=";
	localparam logic [63:0] ID_ABC  = 64'h4847_4645_4443_4241;

	localparam verdict_t V_ERR    = '{ST_ERR, 64'd0, 4'd0, 8'd0, 8'd0};
	localparam verdict_t V_NOT_US = '{ST_NOT_US, 64'd0, 4'd0, 8'd0, 8'd0};
	localparam verdict_t V_OK_M1  = '{ST_OK, 64'h316D, 4'd2, 8'd24, 8'd5};

	// One directed line: '#' expands to fill copies of 'p', '~' is a NUL character
	typedef struct {
		bit          set_id;
		logic [63:0] id;
		string       text;
		int          fill;
		bit          typed;
		verdict_t    want;
	} line_row_t;

	line_row_t line_table [22] = '{
		'{1'b0, 64'd0, "", 0, 1'b1, V_ERR},
		'{1'b0, 64'd0, "+RCV", 0, 1'b1, V_ERR},
		'{1'b0, 64'd0, "+RCX=1,2,", 0, 1'b1, V_ERR},
		'{1'b0, 64'd0, "+RCV=1,2,Z::a::b,", 0, 1'b1, V_NOT_US},
		'{1'b0, 64'd0, "+RCV=1,2,~Q", 0, 1'b1, V_ERR},
		'{1'b1, ID_ABC, "+RCV=5,12,ABCDEFGH::m1::hello,x", 0, 1'b1, V_OK_M1},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDXFGH::m::p,", 0, 1'b1, V_NOT_US},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH:x", 0, 1'b1, V_ERR},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH::::p,", 0, 1'b1, V_ERR},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH::m", 0, 1'b1, V_ERR},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH::m~zz", 0, 1'b1, V_ERR},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH::12345678abc,", 0, 1'b0, '0},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH::12345678::p,", 0, 1'b0, '0},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH::a:b::,", 0, 1'b0, '0},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH::id::#,", 63, 1'b0, '0},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH::id::#,", 64, 1'b1, V_ERR},
		'{1'b0, 64'd0, "+RCV=#,12,ABCDEFGH::id::pl,", 240, 1'b0, '0},
		'{1'b0, 64'd0, "+RCV=,,ABCDEFGH::q::r,", 0, 1'b0, '0},
		'{1'b0, 64'd0, "+RCV=5,12,ABCDEFGH::m1::hi,~more", 0, 1'b0, '0},
		'{1'b0, 64'd0, "+RCV~junk", 0, 1'b1, V_ERR},
		'{1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
			"+RCV=a,b,\377\377\377\377\377\377\377\377::\377::\200,", 0, 1'b0, '0},
		'{1'b0, 64'd0, "+RCV=a,b,\377\377\377\377\377\377\377\376", 0, 1'b1, V_NOT_US}
	};

	logic        clk;
	logic        arst_n;
	logic        node_id_we;
	logic [63:0] node_id_wdata;

	rlfp_char_if    char_bus ();
	rlfp_verdict_if verdict_bus ();

	receive_line_field_parser #(
		.ID_CHARS    (ID_CHARS),
		.MSGID_MAX   (MSGID_MAX),
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_id_we (node_id_we),
		.node_id    (node_id_wdata),
		.in_ch      (char_bus),
		.out_ch     (verdict_bus)
	);

	// Line parser prediction state
	phase_t      pl_phase;
	int unsigned pl_count;
	int unsigned pl_offset;
	int unsigned pl_commas;
	int unsigned pl_id_len;
	int unsigned pl_pay_start;
	logic [7:0]  pl_held;
	bit          pl_held_ok;
	logic [63:0] pl_id;
	logic [63:0] node_id_copy;

	verdict_t   verdicts_due[$];
	logic [7:0] line_chars[$];
	bit         typed_pending;
	verdict_t   typed_want;
	bit         no_gaps;
	bit         pressure_done;
	int         chars_taken;
	int         random_lines;
	int         id_loads;
	int         mismatches;
	int         stuck_cycles;
	int         status_seen [4];

	function automatic void clear_line();
		pl_phase = PH_PREFIX;
		pl_count = 0;
		pl_offset = 0;
		pl_commas = 0;
		pl_id_len = 0;
		pl_pay_start = 0;
		pl_held = '0;
		pl_held_ok = 1'b0;
		pl_id = '0;
	endfunction

	// Give the line's verdict and ignore the rest of it
	function automatic verdict_t close_line(status_t st);
		verdict_t v;
		v = '0;
		v.status = st;
		if (st == ST_OK) begin
			v.msg_id = pl_id;
			v.msg_id_len = 4'(pl_id_len);
			v.payload_start = 8'(pl_pay_start);
			v.pay_len = 8'(pl_count);
		end
		pl_phase = PH_DONE;
		return v;
	endfunction

	function automatic bit payload_step(input logic [7:0] c, output verdict_t v);
		v = '0;
		if (c == CHAR_COMMA) begin
			v = close_line(ST_OK);
			return 1'b1;
		end
		pl_count++;
		if (pl_count >= PAYLOAD_MAX) begin
			v = close_line(ST_ERR);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the line parser by one transaction; returns 1 when a verdict is due
	function automatic bit line_step(input logic [7:0] c, input logic eol, output verdict_t v);
		int unsigned at;
		v = '0;
		if (eol) begin
			if (pl_phase != PH_DONE) begin
				v = close_line(ST_ERR);
				clear_line();
				return 1'b1;
			end
			clear_line();
			return 1'b0;
		end
		at = pl_offset;
		if (pl_offset < 255)
			pl_offset++;
		if (pl_phase == PH_DONE)
			return 1'b0;
		if (c == CHAR_NUL) begin
			v = close_line(ST_ERR);
			return 1'b1;
		end
		case (pl_phase)
			PH_PREFIX: begin
				if (c != RCV_TAG[39 - 8 * pl_count -: 8]) begin
					v = close_line(ST_ERR);
					return 1'b1;
				end
				pl_count++;
				if (pl_count == PREFIX_LEN) begin
					pl_phase = PH_COMMA;
					pl_count = 0;
				end
			end
			PH_COMMA: begin
				if (c == CHAR_COMMA) begin
					pl_commas++;
					if (pl_commas >= COMMAS_TO_ID) begin
						pl_phase = PH_ID;
						pl_count = 0;
					end
				end
			end
			PH_ID: begin
				if (c != node_id_copy[8 * pl_count +: 8]) begin
					v = close_line(ST_NOT_US);
					return 1'b1;
				end
				pl_count++;
				if (pl_count >= ID_CHARS)
					pl_phase = PH_COL1;
			end
			PH_COL1: begin
				if (c != CHAR_COLON) begin
					v = close_line(ST_ERR);
					return 1'b1;
				end
				pl_phase = PH_COL2;
			end
			PH_COL2: begin
				if (c != CHAR_COLON) begin
					v = close_line(ST_ERR);
					return 1'b1;
				end
				pl_phase = PH_MSGID;
				pl_held_ok = 1'b0;
			end
			PH_MSGID: begin
				// hold each id character until the next one shows it is not a terminator
				if (!pl_held_ok) begin
					pl_held = c;
					pl_held_ok = 1'b1;
					return 1'b0;
				end
				if (pl_held == CHAR_COLON && c == CHAR_COLON) begin
					pl_held_ok = 1'b0;
					if (pl_id_len == 0) begin
						v = close_line(ST_ERR);
						return 1'b1;
					end
					pl_phase = PH_PAY;
					pl_count = 0;
					pl_pay_start = (at < 255) ? at + 1 : 255;
					return 1'b0;
				end
				pl_id[8 * pl_id_len +: 8] = pl_held;
				pl_id_len++;
				// id full without a closing pair: this character opens the payload
				if (pl_id_len >= MSGID_MAX) begin
					pl_held_ok = 1'b0;
					pl_phase = PH_PAY;
					pl_count = 0;
					pl_pay_start = at;
					return payload_step(c, v);
				end
				pl_held = c;
			end
			PH_PAY: return payload_step(c, v);
			default: return 1'b0;
		endcase
		return 1'b0;
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255, 1));
		while (c == CHAR_COMMA || c == CHAR_COLON);
		return c;
	endfunction

	// Offer one character, hold it until taken, then predict its verdict
	task automatic send_item(input logic [7:0] ch, input logic eol);
		verdict_t v;
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 9) begin
			char_bus.valid <= 1'b0;
			@(negedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.char_in <= ch;
		char_bus.end_of_line <= eol;
		do
			@(posedge clk);
		while (!char_bus.ready);
		chars_taken++;
		if (line_step(ch, eol, v)) begin
			if (typed_pending) begin
				v = typed_want;
				typed_pending = 1'b0;
			end
			verdicts_due.push_back(v);
		end
	endtask

	task automatic send_line();
		foreach (line_chars[i])
			send_item(line_chars[i], 1'b0);
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic go_quiet();
		@(negedge clk);
		char_bus.valid <= 1'b0;
	endtask

	// Write the node id once every verdict is out and the pipeline has drained
	task automatic load_node_id(input logic [63:0] value);
		go_quiet();
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (VERDICT_LATENCY + 2) @(posedge clk);
		@(negedge clk);
		node_id_we <= 1'b1;
		node_id_wdata <= value;
		node_id_copy = value;
		id_loads++;
		@(negedge clk);
		node_id_we <= 1'b0;
	endtask

	// Build a random line: mostly well formed with random content, some noise
	task automatic make_line();
		int n, k, r;
		logic [7:0] b;
		line_chars.delete();
		if ($urandom_range(99) < 8) begin
			n = $urandom_range(40);
			repeat (n) line_chars.push_back(8'($urandom_range(255)));
			return;
		end
		for (k = 0; k < 5; k++)
			line_chars.push_back(RCV_TAG[39 - 8 * k -: 8]);
		// leading fields, now and then a long one to saturate the offset
		n = ($urandom_range(99) < 4) ? $urandom_range(250, 200) : $urandom_range(4);
		repeat (n) line_chars.push_back(plain_char());
		line_chars.push_back(CHAR_COMMA);
		repeat ($urandom_range(4)) line_chars.push_back(plain_char());
		line_chars.push_back(CHAR_COMMA);
		// node id, sometimes with one character off
		r = ($urandom_range(99) < 15) ? $urandom_range(ID_CHARS - 1) : -1;
		for (k = 0; k < ID_CHARS; k++) begin
			b = node_id_copy[8 * k +: 8];
			if (k == r)
				b = b ^ 8'($urandom_range(255, 1));
			line_chars.push_back(b);
		end
		line_chars.push_back(CHAR_COLON);
		line_chars.push_back(($urandom_range(99) < 5) ? plain_char() : CHAR_COLON);
		// message id: closed by a colon pair, or run past its limit
		if ($urandom_range(99) < 15) begin
			repeat (MSGID_MAX + $urandom_range(3)) line_chars.push_back(plain_char());
		end else begin
			n = ($urandom_range(99) < 3) ? 0 : $urandom_range(MSGID_MAX, 1);
			repeat (n) line_chars.push_back(($urandom_range(99) < 10) ? CHAR_COLON : plain_char());
			line_chars.push_back(CHAR_COLON);
			line_chars.push_back(CHAR_COLON);
		end
		// payload: mostly short, some around the length limit
		r = $urandom_range(99);
		n = (r < 75) ? $urandom_range(16) : (r < 92) ? $urandom_range(70, 55) : $urandom_range(54, 17);
		repeat (n) line_chars.push_back(plain_char());
		if ($urandom_range(99) < 95)
			line_chars.push_back(CHAR_COMMA);
		repeat ($urandom_range(4)) line_chars.push_back(8'($urandom_range(255)));
		// corrupt one character, or cut the line short
		if ($urandom_range(99) < 15)
			line_chars[$urandom_range(line_chars.size() - 1)] = 8'($urandom_range(255));
		if ($urandom_range(99) < 5) begin
			n = $urandom_range(line_chars.size() - 1);
			while (line_chars.size() > n)
				void'(line_chars.pop_back());
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Verdict receiver: random stalls, and one long hold-off from the first
	// transaction on, so the short directed lines back up the input
	initial begin
		verdict_bus.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!pressure_done && chars_taken > 0) begin
				verdict_bus.ready <= 1'b0;
				repeat (PRESSURE_CYCLES - 1) @(negedge clk);
				pressure_done = 1'b1;
			end else begin
				verdict_bus.ready <= no_gaps || ($urandom_range(99) >= 9);
			end
		end
	end

	// Compare each verdict with the oldest one predicted
	always @(posedge clk) begin : verdict_check
		verdict_t want;
		if (verdict_bus.valid && verdict_bus.ready) begin
			status_seen[verdict_bus.status]++;
			if (verdicts_due.size() == 0) begin
				$error("verdict with no line pending, status %0d", verdict_bus.status);
				mismatches++;
			end else begin
				want = verdicts_due.pop_front();
				if (verdict_bus.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, verdict_bus.status);
					mismatches++;
				end
				if (verdict_bus.msg_id !== want.msg_id) begin
					$error("msg_id: expected %h, got %h", want.msg_id, verdict_bus.msg_id);
					mismatches++;
				end
				if (verdict_bus.msg_id_len !== want.msg_id_len) begin
					$error("msg_id_len: expected %0d, got %0d", want.msg_id_len,
						verdict_bus.msg_id_len);
					mismatches++;
				end
				if (verdict_bus.payload_start !== want.payload_start) begin
					$error("payload_start: expected %0d, got %0d", want.payload_start,
						verdict_bus.payload_start);
					mismatches++;
				end
				if (verdict_bus.pay_len !== want.pay_len) begin
					$error("pay_len: expected %0d, got %0d", want.pay_len,
						verdict_bus.pay_len);
					mismatches++;
				end
			end
		end
	end

	// Stop a hung run: count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((char_bus.valid && char_bus.ready) || (verdict_bus.valid && verdict_bus.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Timeout after %0d idle cycles", stuck_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin : stimulus
		int k, ph, chars_base, phase_end;
		logic [7:0] ch;
		logic [63:0] next_id;
		arst_n = 1'b0;
		node_id_we = 1'b0;
		node_id_wdata = '0;
		char_bus.valid = 1'b0;
		char_bus.char_in = '0;
		char_bus.end_of_line = 1'b0;
		node_id_copy = '0;
		clear_line();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines
		foreach (line_table[r]) begin
			if (line_table[r].set_id)
				load_node_id(line_table[r].id);
			line_chars.delete();
			for (k = 0; k < line_table[r].text.len(); k++) begin
				ch = line_table[r].text[k];
				if (ch == "#")
					repeat (line_table[r].fill) line_chars.push_back("p");
				else if (ch == "~")
					line_chars.push_back(CHAR_NUL);
				else
					line_chars.push_back(ch);
			end
			typed_pending = line_table[r].typed;
			typed_want = line_table[r].want;
			send_line();
		end

		// random lines under a sequence of node ids, one phase without gaps
		chars_base = chars_taken;
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: next_id = '0;
				1, 4: begin
					for (k = 0; k < 8; k++)
						next_id[8 * k +: 8] = 8'($urandom_range(126, 33));
				end
				2: next_id = '1;
				default: next_id = {$urandom, $urandom};
			endcase
			load_node_id(next_id);
			no_gaps = (ph == 2);
			phase_end = chars_base + 100 + ph * ((RANDOM_ITEMS - 100) / 4);
			while (chars_taken < phase_end) begin
				make_line();
				send_line();
				random_lines++;
			end
		end
		no_gaps = 1'b0;

		// drain and let the last verdict settle
		go_quiet();
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (VERDICT_LATENCY + 6) @(posedge clk);
		if (verdicts_due.size() != 0) begin
			$error("%0d verdicts never arrived", verdicts_due.size());
			mismatches++;
		end

		$display("Sent %0d characters in %0d directed and %0d random lines, %0d node id writes",
			chars_taken, $size(line_table), random_lines, id_loads);
		$display("Verdicts: %0d data, %0d not addressed, %0d parse errors",
			status_seen[ST_OK], status_seen[ST_NOT_US], status_seen[ST_ERR]);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
